// ===== hdl/spcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shape pair collision package
// Shared constants and codes for the shape pair collision block.
// ----------------------------------------------------------------------------
package spcp_pkg;

    localparam int DEF_FRAC_BITS  = 8;
    localparam int DEF_COORD_BITS = 24;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] KIND_CIRCLE = 2'd0;
    localparam logic [1:0] KIND_RECT   = 2'd1;

    typedef enum logic [1:0] {
        MODE_MISS,
        MODE_BOX,
        MODE_ROUND,
        MODE_CBOX
    } t_mode;

endpackage
`default_nettype wire

// ===== hdl/spcp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shape pair collision channels
// Valid/ready channels for shape pair words and collision result words.
// ----------------------------------------------------------------------------
interface spcp_in_if import spcp_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   type_a;
    logic signed [COORD_BITS-1:0] x_a;
    logic signed [COORD_BITS-1:0] y_a;
    logic [COORD_BITS-2:0]        w_a;
    logic [COORD_BITS-2:0]        h_a;
    logic [1:0]                   type_b;
    logic signed [COORD_BITS-1:0] x_b;
    logic signed [COORD_BITS-1:0] y_b;
    logic [COORD_BITS-2:0]        w_b;
    logic [COORD_BITS-2:0]        h_b;

    modport source (output valid, type_a, x_a, y_a, w_a, h_a,
                    type_b, x_b, y_b, w_b, h_b, input ready);
    modport sink (input valid, type_a, x_a, y_a, w_a, h_a,
                  type_b, x_b, y_b, w_b, h_b, output ready);
endinterface

interface spcp_out_if import spcp_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] push_x;
    logic signed [COORD_BITS-1:0] push_y;
    logic [COORD_BITS-2:0]        depth;

    modport source (output valid, hit, push_x, push_y, depth, input ready);
    modport sink (input valid, hit, push_x, push_y, depth, output ready);
endinterface
`default_nettype wire

// ===== hdl/spcp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shape pair collision front end
// Captures a pair word, runs the box overlap test and the box push, and
// prepares the offset and the radius or radius sum for the round tests.
// ----------------------------------------------------------------------------
module spcp_front import spcp_pkg::*; #(
    parameter int  COORD_BITS = DEF_COORD_BITS,
    parameter type t_job      = logic
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    spcp_in_if.sink i_pair,
    output logic   o_push,
    output t_job   o_job,
    input  wire    i_full
);
    localparam int C = COORD_BITS;
    localparam int E = COORD_BITS + 3;

    typedef struct packed {
        logic [1:0]        ta;
        logic signed [C-1:0] xa, ya;
        logic [C-2:0]      wa, ha;
        logic [1:0]        tb;
        logic signed [C-1:0] xb, yb;
        logic [C-2:0]      wb, hb;
    } t_pair;

    logic  r_v;
    t_pair r_in;

    logic signed [E-1:0] ax, ay, bx, by, aw, ah, bw, bh;
    logic signed [E-1:0] ar, ab, br, bb, lft, rgt, top, bot, iw, ih;
    logic signed [E-1:0] cax, cay, cbx, cby, cx, cy;
    logic signed [E-1:0] rx, ry, rw, rh, lo_x, hi_x, lo_y, hi_y, nx, ny;
    logic                a_circ, b_circ, a_rect, b_rect, ovl;
    logic [C-2:0]        cw;

    assign i_pair.ready = !r_v || !i_full;
    assign o_push       = r_v && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_pair.ready) begin
            r_v <= i_pair.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pair.ready && i_pair.valid) begin
            r_in <= '{ta: i_pair.type_a, xa: i_pair.x_a, ya: i_pair.y_a,
                      wa: i_pair.w_a, ha: i_pair.h_a,
                      tb: i_pair.type_b, xb: i_pair.x_b, yb: i_pair.y_b,
                      wb: i_pair.w_b, hb: i_pair.h_b};
        end
    end

    always_comb begin
        ax = {{3{r_in.xa[C-1]}}, r_in.xa};
        ay = {{3{r_in.ya[C-1]}}, r_in.ya};
        bx = {{3{r_in.xb[C-1]}}, r_in.xb};
        by = {{3{r_in.yb[C-1]}}, r_in.yb};
        aw = $signed({4'b0000, r_in.wa});
        ah = $signed({4'b0000, r_in.ha});
        bw = $signed({4'b0000, r_in.wb});
        bh = $signed({4'b0000, r_in.hb});
        ar = ax + aw;
        ab = ay + ah;
        br = bx + bw;
        bb = by + bh;
        lft = (ax > bx) ? ax : bx;
        rgt = (ar < br) ? ar : br;
        top = (ay > by) ? ay : by;
        bot = (ab < bb) ? ab : bb;
        iw  = rgt - lft;
        ih  = bot - top;
        ovl = (lft < rgt) && (top < bot);
        cax = (ax <<< 1) + aw;
        cay = (ay <<< 1) + ah;
        cbx = (bx <<< 1) + bw;
        cby = (by <<< 1) + bh;

        a_circ = (r_in.ta == KIND_CIRCLE);
        b_circ = (r_in.tb == KIND_CIRCLE);
        a_rect = (r_in.ta == KIND_RECT);
        b_rect = (r_in.tb == KIND_RECT);

        cx = a_circ ? cax : cbx;
        cy = a_circ ? cay : cby;
        cw = a_circ ? r_in.wa : r_in.wb;
        rx = a_circ ? bx : ax;
        ry = a_circ ? by : ay;
        rw = a_circ ? bw : aw;
        rh = a_circ ? bh : ah;
        lo_x = rx <<< 1;
        hi_x = (rx <<< 1) + (rw <<< 1);
        lo_y = ry <<< 1;
        hi_y = (ry <<< 1) + (rh <<< 1);
        nx = (cx < lo_x) ? lo_x : ((cx > hi_x) ? hi_x : cx);
        ny = (cy < lo_y) ? lo_y : ((cy > hi_y) ? hi_y : cy);

        o_job      = '0;
        o_job.mode = MODE_BOX;
        if (!ovl) begin
            o_job.mode = MODE_MISS;
        end else if (a_circ && b_circ) begin
            o_job.mode = MODE_ROUND;
            o_job.dx   = cbx - cax;
            o_job.dy   = cby - cay;
            o_job.r    = {1'b0, r_in.wa} + {1'b0, r_in.wb};
        end else if ((a_circ && b_rect) || (a_rect && b_circ)) begin
            o_job.mode = MODE_CBOX;
            o_job.neg  = a_rect;
            o_job.dx   = cx - nx;
            o_job.dy   = cy - ny;
            o_job.r    = {1'b0, cw};
        end else if (iw < ih) begin
            o_job.bx = (cax < cbx) ? C'(-iw) : C'(iw);
            o_job.bd = iw[C-2:0];
        end else begin
            o_job.by = (cay < cby) ? C'(-ih) : C'(ih);
            o_job.bd = ih[C-2:0];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/spcp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shape pair collision job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module spcp_fifo import spcp_pkg::*; #(
    parameter type t_data = logic,
    parameter int  DEPTH  = QUEUE_DEPTH
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_data i_data,
    output logic  o_full,
    input  wire   i_pop,
    output logic  o_nempty,
    output t_data o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data          r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full   = (r_cnt == CW'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/spcp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shape pair collision back end
// Pipelined round test: magnitudes, squares, compare, square root,
// penetration, scaling products, scaling division and final saturation.
// ----------------------------------------------------------------------------
module spcp_back import spcp_pkg::*; #(
    parameter int  FRAC_BITS  = DEF_FRAC_BITS,
    parameter int  COORD_BITS = DEF_COORD_BITS,
    parameter type t_job      = logic
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_nempty,
    input  t_job  i_job,
    output logic  o_pop,
    spcp_out_if.source o_res
);
    localparam int C  = COORD_BITS;
    localparam int E  = COORD_BITS + 3;
    localparam logic [63:0] EPS_SQ = (64'd1 << (2 * FRAC_BITS + 2)) / 64'd1000000;

    localparam int ST_MAG = 0;
    localparam int ST_SQR = 1;
    localparam int ST_CMP = 2;
    localparam int SQ0    = 3;
    localparam int ST_PEN = C + 3;
    localparam int ST_MUL = C + 4;
    localparam int ST_DIV = C + 5;
    localparam int DV0    = C + 6;
    localparam int ST_OUT = 2 * C + 6;
    localparam int NS     = 2 * C + 7;

    typedef struct packed {
        t_mode               mode;
        logic                neg;
        logic signed [C-1:0] bx, by;
        logic [C-2:0]        bd;
        logic                sx, sy, rej, hit, eps;
        logic [C-1:0]        ux, uy, r;
        logic [2*C-1:0]      ux2, uy2, r2, d2;
        logic [C+1:0]        rem;
        logic [C-1:0]        root;
        logic [2*C-1:0]      sqn;
        logic [C-1:0]        pen;
        logic [2*C-1:0]      prx, pry;
        logic [C:0]          dvd;
        logic [2*C:0]        rmx, rmy;
        logic [C-1:0]        qx, qy;
        logic                ohit;
        logic signed [C-1:0] opx, opy;
        logic [C-2:0]        odep;
    } t_st;

    function automatic logic signed [C-1:0] sat(input logic signed [C+1:0] v);
        logic signed [C+1:0] pmax, pmin;
        pmax = $signed({3'b000, {(C-1){1'b1}}});
        pmin = $signed({3'b111, {(C-1){1'b0}}});
        if (v > pmax) begin
            return pmax[C-1:0];
        end else if (v < pmin) begin
            return pmin[C-1:0];
        end
        return v[C-1:0];
    endfunction

    t_st  r_st [NS];
    t_st  n_st [NS];
    logic [NS-1:0] r_v;
    logic adv;

    assign adv   = !r_v[NS-1] || o_res.ready;
    assign o_pop = i_nempty && adv;

    assign o_res.valid  = r_v[NS-1];
    assign o_res.hit    = r_st[NS-1].ohit;
    assign o_res.push_x = r_st[NS-1].opx;
    assign o_res.push_y = r_st[NS-1].opy;
    assign o_res.depth  = r_st[NS-1].odep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-2:0], i_nempty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st <= n_st;
        end
    end

    always_comb begin
        logic [E-1:0] ax, ay;
        ax = i_job.dx[E-1] ? E'(-i_job.dx) : E'(i_job.dx);
        ay = i_job.dy[E-1] ? E'(-i_job.dy) : E'(i_job.dy);
        n_st[ST_MAG]      = '0;
        n_st[ST_MAG].mode = i_job.mode;
        n_st[ST_MAG].neg  = i_job.neg;
        n_st[ST_MAG].bx   = i_job.bx;
        n_st[ST_MAG].by   = i_job.by;
        n_st[ST_MAG].bd   = i_job.bd;
        n_st[ST_MAG].sx   = i_job.dx[E-1];
        n_st[ST_MAG].sy   = i_job.dy[E-1];
        n_st[ST_MAG].r    = i_job.r;
        n_st[ST_MAG].ux   = ax[C-1:0];
        n_st[ST_MAG].uy   = ay[C-1:0];
        n_st[ST_MAG].rej  = (ax >= E'(i_job.r)) || (ay >= E'(i_job.r));
    end

    always_comb begin
        n_st[ST_SQR]     = r_st[ST_MAG];
        n_st[ST_SQR].ux2 = r_st[ST_MAG].ux * r_st[ST_MAG].ux;
        n_st[ST_SQR].uy2 = r_st[ST_MAG].uy * r_st[ST_MAG].uy;
        n_st[ST_SQR].r2  = r_st[ST_MAG].r * r_st[ST_MAG].r;
    end

    always_comb begin
        logic [2*C:0] sum;
        sum = {1'b0, r_st[ST_SQR].ux2} + {1'b0, r_st[ST_SQR].uy2};
        n_st[ST_CMP]      = r_st[ST_SQR];
        n_st[ST_CMP].hit  = !r_st[ST_SQR].rej && (sum < {1'b0, r_st[ST_SQR].r2});
        n_st[ST_CMP].d2   = sum[2*C-1:0];
        n_st[ST_CMP].sqn  = sum[2*C-1:0];
        n_st[ST_CMP].rem  = '0;
        n_st[ST_CMP].root = '0;
    end

    for (genvar gi = 0; gi < C; gi++) begin : g_sqrt
        always_comb begin
            logic [C+3:0] rn, tr;
            rn = {r_st[SQ0+gi-1].rem, r_st[SQ0+gi-1].sqn[2*C-1:2*C-2]};
            tr = {2'b00, r_st[SQ0+gi-1].root, 2'b01};
            n_st[SQ0+gi]     = r_st[SQ0+gi-1];
            n_st[SQ0+gi].sqn = r_st[SQ0+gi-1].sqn << 2;
            if (rn >= tr) begin
                n_st[SQ0+gi].rem  = (C+2)'(rn - tr);
                n_st[SQ0+gi].root = {r_st[SQ0+gi-1].root[C-2:0], 1'b1};
            end else begin
                n_st[SQ0+gi].rem  = rn[C+1:0];
                n_st[SQ0+gi].root = {r_st[SQ0+gi-1].root[C-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_st[ST_PEN]     = r_st[ST_PEN-1];
        n_st[ST_PEN].pen = r_st[ST_PEN-1].r - r_st[ST_PEN-1].root;
        n_st[ST_PEN].eps = (64'(r_st[ST_PEN-1].d2) <= EPS_SQ) ||
                           (r_st[ST_PEN-1].root == '0);
    end

    always_comb begin
        n_st[ST_MUL]     = r_st[ST_PEN];
        n_st[ST_MUL].prx = r_st[ST_PEN].ux * r_st[ST_PEN].pen;
        n_st[ST_MUL].pry = r_st[ST_PEN].uy * r_st[ST_PEN].pen;
    end

    always_comb begin
        n_st[ST_DIV]     = r_st[ST_MUL];
        n_st[ST_DIV].rmx = {1'b0, r_st[ST_MUL].prx} + (2*C+1)'(r_st[ST_MUL].root);
        n_st[ST_DIV].rmy = {1'b0, r_st[ST_MUL].pry} + (2*C+1)'(r_st[ST_MUL].root);
        n_st[ST_DIV].dvd = {r_st[ST_MUL].root, 1'b0};
        n_st[ST_DIV].qx  = '0;
        n_st[ST_DIV].qy  = '0;
    end

    for (genvar gi = 0; gi < C; gi++) begin : g_div
        always_comb begin
            logic [2*C:0] sh;
            sh = (2*C+1)'(r_st[DV0+gi-1].dvd) << (C - 1 - gi);
            n_st[DV0+gi] = r_st[DV0+gi-1];
            if (r_st[DV0+gi-1].rmx >= sh) begin
                n_st[DV0+gi].rmx         = r_st[DV0+gi-1].rmx - sh;
                n_st[DV0+gi].qx[C-1-gi] = 1'b1;
            end
            if (r_st[DV0+gi-1].rmy >= sh) begin
                n_st[DV0+gi].rmy         = r_st[DV0+gi-1].rmy - sh;
                n_st[DV0+gi].qy[C-1-gi] = 1'b1;
            end
        end
    end

    always_comb begin
        t_st                 s;
        logic [C:0]          du;
        logic signed [C+1:0] vx, vy, qx, qy;
        s  = r_st[ST_OUT-1];
        du = ({1'b0, s.pen} + 1'b1) >> 1;
        qx = $signed({2'b00, s.qx});
        qy = $signed({2'b00, s.qy});
        if (s.eps) begin
            vx = '0;
            vy = (s.mode == MODE_CBOX) ? -$signed({1'b0, du}) : '0;
        end else begin
            vx = s.sx ? -qx : qx;
            vy = s.sy ? -qy : qy;
        end
        if (s.neg) begin
            vx = -vx;
            vy = -vy;
        end
        n_st[ST_OUT] = s;
        unique case (s.mode)
            MODE_MISS, MODE_BOX: begin
                n_st[ST_OUT].ohit = (s.mode == MODE_BOX);
                n_st[ST_OUT].opx  = s.bx;
                n_st[ST_OUT].opy  = s.by;
                n_st[ST_OUT].odep = s.bd;
            end
            MODE_ROUND, MODE_CBOX: begin
                n_st[ST_OUT].ohit = s.hit;
                n_st[ST_OUT].opx  = s.hit ? sat(vx) : '0;
                n_st[ST_OUT].opy  = s.hit ? sat(vy) : '0;
                if (!s.hit) begin
                    n_st[ST_OUT].odep = '0;
                end else if (du > {2'b00, {(C-1){1'b1}}}) begin
                    n_st[ST_OUT].odep = '1;
                end else begin
                    n_st[ST_OUT].odep = du[C-2:0];
                end
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/shape_pair_collision_penetration_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shape pair collision with penetration vector
// Top level: front end, job queue and pipelined back end.
// ----------------------------------------------------------------------------
// The block takes one shape pair word per cycle unless the input register
// holds a word and the job queue is full, and returns one result word per
// pair, in order. A word passes the input register, a four-entry job queue
// and a back-end pipeline of 2*COORD_BITS+7 stages. The length is set by
// the one-bit-per-stage square root and the one-bit-per-stage scaling
// dividers. When the output stalls, the whole back end holds and the queue
// keeps taking words until it fills.
module shape_pair_collision_penetration_top import spcp_pkg::*; #(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    spcp_in_if.sink     i_pair,
    spcp_out_if.source  o_res
);
    localparam int C = COORD_BITS;

    typedef struct packed {
        t_mode               mode;
        logic                neg;
        logic signed [C+2:0] dx, dy;
        logic [C-1:0]        r;
        logic signed [C-1:0] bx, by;
        logic [C-2:0]        bd;
    } t_job;

    logic push, full, pop, nempty;
    t_job job_in, job_out;

    spcp_front #(.COORD_BITS(COORD_BITS), .t_job(t_job)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (i_pair),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    spcp_fifo #(.t_data(t_job), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (job_in),
        .o_full   (full),
        .i_pop    (pop),
        .o_nempty (nempty),
        .o_data   (job_out)
    );

    spcp_back #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS), .t_job(t_job)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_nempty (nempty),
        .i_job    (job_out),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule
`default_nettype wire

// ===== tb/tb_shape_pair_collision_penetration_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shape pair collision testbench
// Drives shape pair words with random gaps, predicts each collision result
// in the testbench and checks every result word in order against it.
// ----------------------------------------------------------------------------
module tb_shape_pair_collision_penetration_top;
    import spcp_pkg::*;

    localparam int CB = 24;
    localparam int FB = 8;
    localparam longint EPS_SQ = (64'd1 << (2 * FB + 2)) / 64'd1000000;
    localparam longint PMAX = (64'd1 << (CB - 1)) - 1;
    localparam longint PMIN = -PMAX - 1;
    localparam longint DMAX = (64'd1 << (CB - 1)) - 1;
    localparam int LATENCY = 2 * CB + 9;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 1100;

    typedef struct packed {
        logic [1:0] type_a;
        logic signed [CB-1:0] x_a;
        logic signed [CB-1:0] y_a;
        logic [CB-2:0] w_a;
        logic [CB-2:0] h_a;
        logic [1:0] type_b;
        logic signed [CB-1:0] x_b;
        logic signed [CB-1:0] y_b;
        logic [CB-2:0] w_b;
        logic [CB-2:0] h_b;
    } t_pair;

    typedef struct packed {
        logic hit;
        logic signed [CB-1:0] push_x;
        logic signed [CB-1:0] push_y;
        logic [CB-2:0] depth;
    } t_contact;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int errors = 0;
    longint cycles = 0;
    int n_hits = 0;
    int n_checked = 0;

    spcp_in_if #(.COORD_BITS(CB)) pair_if ();
    spcp_out_if #(.COORD_BITS(CB)) res_if ();

    shape_pair_collision_penetration_top #(.FRAC_BITS(FB), .COORD_BITS(CB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pair(pair_if.sink), .o_res(res_if.source)
    );

    always #5 i_clk = ~i_clk;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
    endtask

    function automatic longint isqrt(input longint n);
        longint r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint absl(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clampl(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint push_share(input longint d, input longint pen, input longint s);
        longint q;
        q = (absl(d) * pen + s) / (2 * s);
        return d < 0 ? -q : q;
    endfunction

    // Circle overlap in doubled coordinates; results are hit, px, py, depth.
    function automatic void round_contact(input longint dx, input longint dy,
                                          input longint r, input bit up,
                                          output bit hit, output longint px,
                                          output longint py, output longint dep);
        longint ux, uy, d2, s, pen;
        ux = absl(dx);
        uy = absl(dy);
        hit = 0; px = 0; py = 0; dep = 0;
        if (ux >= r || uy >= r) return;
        if (ux * ux >= r * r - uy * uy) return;
        d2 = ux * ux + uy * uy;
        s = isqrt(d2);
        pen = r - s;
        hit = 1;
        dep = (pen + 1) >>> 1;
        if (d2 > EPS_SQ && s != 0) begin
            px = push_share(dx, pen, s);
            py = push_share(dy, pen, s);
        end else if (up) begin
            py = -dep;
        end
    endfunction

    function automatic void circle_rect(input longint cx0, input longint cy0,
                                        input longint cw, input longint ch,
                                        input longint rx, input longint ry,
                                        input longint rw, input longint rh,
                                        output bit hit, output longint px,
                                        output longint py, output longint dep);
        longint cx, cy, nx, ny;
        cx = 2 * cx0 + cw;
        cy = 2 * cy0 + ch;
        nx = clampl(cx, 2 * rx, 2 * rx + 2 * rw);
        ny = clampl(cy, 2 * ry, 2 * ry + 2 * rh);
        round_contact(cx - nx, cy - ny, cw, 1'b1, hit, px, py, dep);
    endfunction

    function automatic t_contact contact_of(input t_pair p);
        longint ax, ay, aw, ah, bx, by, bw, bh, lf, rt, tp, bt, px, py, dep, iw, ih;
        bit hit;
        t_contact c;
        ax = p.x_a; ay = p.y_a; aw = p.w_a; ah = p.h_a;
        bx = p.x_b; by = p.y_b; bw = p.w_b; bh = p.h_b;
        hit = 0; px = 0; py = 0; dep = 0;
        lf = ax > bx ? ax : bx;
        rt = (ax + aw) < (bx + bw) ? ax + aw : bx + bw;
        tp = ay > by ? ay : by;
        bt = (ay + ah) < (by + bh) ? ay + ah : by + bh;
        if (lf < rt && tp < bt) begin
            if (p.type_a == KIND_CIRCLE && p.type_b == KIND_CIRCLE) begin
                round_contact((2 * bx + bw) - (2 * ax + aw), (2 * by + bh) - (2 * ay + ah),
                              aw + bw, 1'b0, hit, px, py, dep);
            end else if (p.type_a == KIND_CIRCLE && p.type_b == KIND_RECT) begin
                circle_rect(ax, ay, aw, ah, bx, by, bw, bh, hit, px, py, dep);
            end else if (p.type_a == KIND_RECT && p.type_b == KIND_CIRCLE) begin
                circle_rect(bx, by, bw, bh, ax, ay, aw, ah, hit, px, py, dep);
                px = -px;
                py = -py;
            end else begin
                iw = rt - lf;
                ih = bt - tp;
                hit = 1;
                if (iw < ih) begin
                    px = (2 * ax + aw < 2 * bx + bw) ? -iw : iw;
                    dep = iw;
                end else begin
                    py = (2 * ay + ah < 2 * by + bh) ? -ih : ih;
                    dep = ih;
                end
            end
        end
        c.hit = hit;
        c.push_x = clampl(px, PMIN, PMAX);
        c.push_y = clampl(py, PMIN, PMAX);
        c.depth = dep > DMAX ? DMAX : dep;
        return c;
    endfunction

    class contact_board;
        t_contact pending[$];

        function void note_pair(input t_pair p);
            pending.push_back(contact_of(p));
        endfunction

        task check_result(input t_contact got);
            t_contact want;
            if (pending.size() == 0) begin
                report("unexpected word", 0, 0);
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.hit) n_hits++;
            if (got.hit !== want.hit) report("hit", got.hit, want.hit);
            if (got.push_x !== want.push_x) report("push_x", got.push_x, want.push_x);
            if (got.push_y !== want.push_y) report("push_y", got.push_y, want.push_y);
            if (got.depth !== want.depth) report("depth", got.depth, want.depth);
        endtask
    endclass

    contact_board board = new();

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_pair(input t_pair p);
        pair_if.valid <= 1'b1;
        {pair_if.type_a, pair_if.x_a, pair_if.y_a, pair_if.w_a, pair_if.h_a,
         pair_if.type_b, pair_if.x_b, pair_if.y_b, pair_if.w_b, pair_if.h_b} <= p;
        do @(posedge i_clk); while (!pair_if.ready);
        board.note_pair(p);
    endtask

    task automatic send_with_gap(input t_pair p, input bit calm);
        int g;
        g = calm ? 0 : gap_len();
        if (g > 0) begin
            pair_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        send_pair(p);
    endtask

    function automatic t_pair pair_of(input int ka, input longint xa, input longint ya,
                                      input longint wa, input longint ha, input int kb,
                                      input longint xb, input longint yb,
                                      input longint wb, input longint hb);
        t_pair p;
        p.type_a = ka; p.x_a = xa; p.y_a = ya; p.w_a = wa; p.h_a = ha;
        p.type_b = kb; p.x_b = xb; p.y_b = yb; p.w_b = wb; p.h_b = hb;
        return p;
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int mode, span;
        longint base_x, base_y, ra, rb;
        mode = $urandom_range(0, 9);
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if (mode < 2) return p;
        span = mode < 8 ? $urandom_range(4, 4000) : $urandom_range(1000, 8388607);
        base_x = $signed($urandom) % 8000000;
        base_y = $signed($urandom) % 8000000;
        ra = $urandom_range(1, span);
        rb = $urandom_range(1, span);
        p.type_a = $urandom_range(0, 3);
        p.type_b = $urandom_range(0, 3);
        p.w_a = ra;
        p.h_a = p.type_a == KIND_CIRCLE && $urandom_range(0, 3) != 0 ? ra : $urandom_range(1, span);
        p.w_b = rb;
        p.h_b = p.type_b == KIND_CIRCLE && $urandom_range(0, 3) != 0 ? rb : $urandom_range(1, span);
        p.x_a = base_x;
        p.y_a = base_y;
        p.x_b = base_x + $signed($urandom_range(0, 2 * span)) - span;
        p.y_b = base_y + $signed($urandom_range(0, 2 * span)) - span;
        return p;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_result({res_if.hit, res_if.push_x, res_if.push_y, res_if.depth});
    end

    initial begin
        int r;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (cycles > 20000 && cycles < 24000) res_if.ready <= 1'b1;
            else if (r < 70) res_if.ready <= 1'b1;
            else if (r < 97) res_if.ready <= 1'b0;
            else begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(5, 60)) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_pair d[$];
        int k;
        pair_if.valid = 1'b0;
        {pair_if.type_a, pair_if.x_a, pair_if.y_a, pair_if.w_a, pair_if.h_a,
         pair_if.type_b, pair_if.x_b, pair_if.y_b, pair_if.w_b, pair_if.h_b} = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        d.push_back(pair_of(0, 0, 0, 2560, 2560, 0, 1280, 0, 2560, 2560));
        d.push_back(pair_of(0, 0, 0, 2560, 2560, 0, 0, 0, 2560, 2560));
        d.push_back(pair_of(0, 0, 0, 2560, 2560, 0, 2560, 0, 2560, 2560));
        d.push_back(pair_of(0, 0, 0, 2560, 2560, 0, 1800, 1800, 2560, 2560));
        d.push_back(pair_of(0, 0, 0, 2560, 2560, 1, 2000, 500, 3000, 1000));
        d.push_back(pair_of(1, 2000, 500, 3000, 1000, 0, 0, 0, 2560, 2560));
        d.push_back(pair_of(0, 1000, 1000, 512, 512, 1, 0, 0, 4000, 4000));
        d.push_back(pair_of(1, 0, 0, 4000, 4000, 0, 1000, 1000, 512, 512));
        d.push_back(pair_of(1, 0, 0, 1000, 3000, 2, 800, 100, 1000, 3000));
        d.push_back(pair_of(2, 0, 0, 1000, 1000, 2, 500, 500, 1000, 1000));
        d.push_back(pair_of(3, 0, 0, 1000, 1000, 1, -300, 200, 1000, 1000));
        d.push_back(pair_of(2, 0, 0, 1000, 1000, 3, 0, 0, 1000, 1000));
        d.push_back(pair_of(1, 0, 0, 0, 1000, 1, 0, 0, 1000, 1000));
        d.push_back(pair_of(0, -8388608, -8388608, 8388607, 8388607,
                            0, -8388608, -8388608, 8388607, 8388607));
        d.push_back(pair_of(1, -8388608, -8388608, 8388607, 8388607,
                            2, -8388608, 0, 8388607, 8388607));
        d.push_back(pair_of(0, 8388607, 8388607, 8388607, 8388607,
                            1, -8388608, -8388608, 8388607, 8388607));
        d.push_back(pair_of(2, 8388607, 8388607, 1, 1, 2, 8388607, 8388607, 8388607, 8388607));
        d.push_back(pair_of(1, 0, 0, 8388607, 8388607, 0, 4000000, 4000000, 1, 1));
        d.push_back(pair_of(0, 100, 100, 1, 1, 0, 100, 100, 1, 1));
        d.push_back(pair_of(1, 0, 0, 100, 100, 2, 200, 0, 100, 100));
        foreach (d[i]) send_with_gap(d[i], 1'b0);

        for (k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 2) begin
                pair_if.valid <= 1'b0;
                wait (board.pending.size() == 0);
                @(posedge i_clk);
            end
            send_with_gap(random_pair(), k >= 200 && k < 300);
        end
        pair_if.valid <= 1'b0;
        wait (board.pending.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("covered %0d shape pair words, %0d results checked, %0d hits",
                 d.size() + N_RANDOM, n_checked, n_hits);
        if (errors == 0 && board.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/spcp_pkg.sv
hdl/spcp_if.sv
hdl/spcp_front.sv
hdl/spcp_fifo.sv
hdl/spcp_back.sv
hdl/shape_pair_collision_penetration_top.sv
tb/tb_shape_pair_collision_penetration_top.sv
